### hdl/mlp_msh_pkg.sv
package mlp_msh_pkg;

    localparam logic [23:0] SYNC_WORD     = 24'hF8726F;
    localparam logic [7:0]  TYPE_MLP      = 8'hBB;
    localparam logic [7:0]  TYPE_THD      = 8'hBA;
    localparam logic [5:0]  BASE_LENGTH   = 6'd28;
    localparam logic [5:0]  EXT_BASE      = 6'd30;
    localparam logic [3:0]  RATE_NONE     = 4'hF;
    localparam logic [22:0] RATE_44K1     = 23'd44100;
    localparam logic [22:0] RATE_48K      = 23'd48000;
    localparam logic [4:0]  THD_BITS      = 5'd24;

    localparam logic [5:0]  POS_SYNC_LAST = 6'd2;
    localparam logic [5:0]  POS_TYPE      = 6'd3;
    localparam logic [5:0]  POS_EXT_FLAG  = 6'd25;
    localparam logic [5:0]  POS_EXT_COUNT = 6'd26;

    localparam logic [4:0]  ARR_W2_MASK   = 5'b11001;
    localparam logic [12:0] MAP_W2_MASK   = 13'b0011001111001;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNC_ERR = 2'd1,
        ST_TYPE_ERR = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic        stream_kind;
        logic [5:0]  header_length;
        logic [4:0]  grp1_depth;
        logic [4:0]  grp2_depth;
        logic [22:0] group1_rate;
        logic [22:0] group2_rate;
        logic [4:0]  chan_assign;
        logic [3:0]  first_channel_count;
        logic [4:0]  second_channel_count;
        logic [33:0] peak_rate;
        logic [14:0] stream_flags;
    } t_result;

    function automatic logic [22:0] rate_of(input logic [3:0] code);
        logic [22:0] base;
        base = code[3] ? RATE_44K1 : RATE_48K;
        if (code == RATE_NONE) begin
            return 23'd0;
        end
        return base << code[2:0];
    endfunction

    function automatic logic [4:0] quant_bits(input logic [3:0] code);
        case (code)
            4'd0:    return 5'd16;
            4'd1:    return 5'd20;
            4'd2:    return 5'd24;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [3:0] mlp_count(input logic [4:0] arr);
        case (arr)
            5'd0:  return 4'd1;
            5'd1:  return 4'd2;
            5'd2:  return 4'd3;
            5'd3:  return 4'd4;
            5'd4:  return 4'd3;
            5'd5:  return 4'd4;
            5'd6:  return 4'd5;
            5'd7:  return 4'd3;
            5'd8:  return 4'd4;
            5'd9:  return 4'd5;
            5'd10: return 4'd4;
            5'd11: return 4'd5;
            5'd12: return 4'd6;
            5'd13: return 4'd4;
            5'd14: return 4'd5;
            5'd15: return 4'd4;
            5'd16: return 4'd5;
            5'd17: return 4'd6;
            5'd18: return 4'd5;
            5'd19: return 4'd5;
            5'd20: return 4'd6;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [3:0] arr_count(input logic [4:0] arr);
        logic [3:0] sum;
        sum = 4'd0;
        for (int i = 0; i < 5; i++) begin
            if (arr[i]) begin
                sum = sum + (ARR_W2_MASK[i] ? 4'd2 : 4'd1);
            end
        end
        return sum;
    endfunction

    function automatic logic [4:0] map_count(input logic [12:0] map);
        logic [4:0] sum;
        sum = 5'd0;
        for (int i = 0; i < 13; i++) begin
            if (map[i]) begin
                sum = sum + (MAP_W2_MASK[i] ? 5'd2 : 5'd1);
            end
        end
        return sum;
    endfunction

endpackage

### hdl/mlp_major_sync_header_parser.sv
// Major sync header parser for MLP and TrueHD streams. Takes one header word
// per cycle, back to back, with i_start_of_header marking the first word and
// restarting any header in progress. A result is registered from the
// word that completes it: the last header word (28 words, or 30 + 2 * count
// for TrueHD with extensions), or the third or fourth word when the sync or
// the type is wrong. The field decode and the peak bitrate multiply sit
// between the capture registers and the output register; a one-entry hold
// register behind the output takes one more result while the output waits,
// and the input stalls only while both are full.
module mlp_major_sync_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_header_byte,
    input  logic        i_start_of_header,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_stream_kind,
    output logic [5:0]  o_header_length,
    output logic [4:0]  o_grp1_depth,
    output logic [4:0]  o_grp2_depth,
    output logic [22:0] o_group1_rate,
    output logic [22:0] o_group2_rate,
    output logic [4:0]  o_chan_assign,
    output logic [3:0]  o_first_channel_count,
    output logic [4:0]  o_second_channel_count,
    output logic [33:0] o_peak_rate,
    output logic [14:0] o_stream_flags
);

    logic [5:0] r_pos, n_pos;
    logic       r_active, n_active;
    logic       r_ext, n_ext;
    logic [5:0] r_exp, n_exp;
    logic       r_ov, r_hv;
    mlp_msh_pkg::t_result r_out, r_hold, n_res;
    logic       n_emit;

    logic [7:0] r_b0, r_b1, r_b3, r_b4, r_b5, r_b6, r_b7;
    logic [7:0] r_b14, r_b15, r_b16, r_b17;

    logic       accept;
    logic       out_fire;
    logic [5:0] pos;

    assign o_in_ready = !r_hv;
    assign accept     = i_in_valid && o_in_ready;
    assign out_fire   = r_ov && i_out_ready;
    assign pos        = i_start_of_header ? 6'd0 : r_pos;

    always_comb begin
        logic        active;
        logic        thd;
        logic [22:0] r1;
        logic [14:0] peak15;
        logic [37:0] prod;
        logic [4:0]  arr;
        n_pos    = r_pos;
        n_active = r_active;
        n_ext    = r_ext;
        n_exp    = r_exp;
        n_emit   = 1'b0;
        n_res    = '0;
        active   = i_start_of_header || r_active;
        thd      = (r_b3 == mlp_msh_pkg::TYPE_THD);
        r1       = thd ? mlp_msh_pkg::rate_of(r_b4[7:4]) : mlp_msh_pkg::rate_of(r_b5[7:4]);
        peak15   = {r_b14[6:0], r_b15};
        prod     = {23'd0, peak15} * {15'd0, r1};
        arr      = thd ? {r_b5[3:0], r_b6[7]} : r_b7[4:0];
        if (i_start_of_header) begin
            n_ext = 1'b0;
            n_exp = mlp_msh_pkg::BASE_LENGTH;
        end
        if (accept && active) begin
            n_active = 1'b1;
            n_pos    = pos + 6'd1;
            if (pos == mlp_msh_pkg::POS_SYNC_LAST &&
                {r_b0, r_b1, i_header_byte} != mlp_msh_pkg::SYNC_WORD) begin
                n_emit       = 1'b1;
                n_active     = 1'b0;
                n_res.status = mlp_msh_pkg::ST_SYNC_ERR;
            end else if (pos == mlp_msh_pkg::POS_TYPE &&
                         i_header_byte != mlp_msh_pkg::TYPE_MLP &&
                         i_header_byte != mlp_msh_pkg::TYPE_THD) begin
                n_emit       = 1'b1;
                n_active     = 1'b0;
                n_res.status = mlp_msh_pkg::ST_TYPE_ERR;
            end else begin
                if (pos == mlp_msh_pkg::POS_EXT_FLAG && thd) begin
                    n_ext = i_header_byte[0];
                end
                if (pos == mlp_msh_pkg::POS_EXT_COUNT && r_ext) begin
                    n_exp = mlp_msh_pkg::EXT_BASE + {1'b0, i_header_byte[7:4], 1'b0};
                end
                if ({1'b0, pos} + 7'd1 >= {1'b0, n_exp}) begin
                    n_emit                     = 1'b1;
                    n_active                   = 1'b0;
                    n_res.status               = mlp_msh_pkg::ST_OK;
                    n_res.stream_kind          = thd;
                    n_res.header_length        = n_exp;
                    n_res.group1_rate          = r1;
                    n_res.chan_assign          = arr;
                    n_res.peak_rate            = 34'((prod + 38'd8) >> 4);
                    n_res.stream_flags         = {r_b14[7], r_b16[7:4], r_b16[1:0], r_b17};
                    if (thd) begin
                        n_res.grp1_depth           = mlp_msh_pkg::THD_BITS;
                        n_res.grp2_depth           = 5'd0;
                        n_res.group2_rate          = 23'd0;
                        n_res.first_channel_count  = mlp_msh_pkg::arr_count(arr);
                        n_res.second_channel_count =
                            mlp_msh_pkg::map_count({r_b6[4:0], r_b7});
                    end else begin
                        n_res.grp1_depth           = mlp_msh_pkg::quant_bits(r_b4[7:4]);
                        n_res.grp2_depth           = mlp_msh_pkg::quant_bits(r_b4[3:0]);
                        n_res.group2_rate          = mlp_msh_pkg::rate_of(r_b5[3:0]);
                        n_res.first_channel_count  = mlp_msh_pkg::mlp_count(arr);
                        n_res.second_channel_count = 5'd0;
                    end
                end
            end
        end else if (accept) begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 6'd0;
            r_active <= 1'b0;
            r_ext    <= 1'b0;
            r_exp    <= mlp_msh_pkg::BASE_LENGTH;
            r_ov     <= 1'b0;
            r_hv     <= 1'b0;
        end else begin
            if (accept) begin
                r_pos    <= n_pos;
                r_active <= n_active;
                r_ext    <= n_ext;
                r_exp    <= n_exp;
            end
            if (!r_ov || out_fire) begin
                if (r_hv) begin
                    r_ov <= 1'b1;
                    r_hv <= 1'b0;
                end else begin
                    r_ov <= n_emit;
                end
            end else if (n_emit) begin
                r_hv <= 1'b1;
            end
        end
    end

    // load the output and hold registers and capture the words that feed the decode; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!r_ov || out_fire) begin
            r_out <= r_hv ? r_hold : n_res;
        end else if (n_emit) begin
            r_hold <= n_res;
        end
        if (accept && (i_start_of_header || r_active)) begin
            case (pos)
                6'd0:    r_b0  <= i_header_byte;
                6'd1:    r_b1  <= i_header_byte;
                6'd3:    r_b3  <= i_header_byte;
                6'd4:    r_b4  <= i_header_byte;
                6'd5:    r_b5  <= i_header_byte;
                6'd6:    r_b6  <= i_header_byte;
                6'd7:    r_b7  <= i_header_byte;
                6'd14:   r_b14 <= i_header_byte;
                6'd15:   r_b15 <= i_header_byte;
                6'd16:   r_b16 <= i_header_byte;
                6'd17:   r_b17 <= i_header_byte;
                default: ;
            endcase
        end
    end

    assign o_out_valid            = r_ov;
    assign o_status               = r_out.status;
    assign o_stream_kind          = r_out.stream_kind;
    assign o_header_length        = r_out.header_length;
    assign o_grp1_depth           = r_out.grp1_depth;
    assign o_grp2_depth           = r_out.grp2_depth;
    assign o_group1_rate          = r_out.group1_rate;
    assign o_group2_rate          = r_out.group2_rate;
    assign o_chan_assign          = r_out.chan_assign;
    assign o_first_channel_count  = r_out.first_channel_count;
    assign o_second_channel_count = r_out.second_channel_count;
    assign o_peak_rate            = r_out.peak_rate;
    assign o_stream_flags         = r_out.stream_flags;

    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hv |-> r_ov)
        else $error("hold register full while output empty");

    a_pos_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_pos < r_exp)
        else $error("word position past header length");

    a_length_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_exp[0] && r_exp >= mlp_msh_pkg::BASE_LENGTH)
        else $error("expected header length malformed");

    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == mlp_msh_pkg::ST_OK) |->
            o_header_length >= mlp_msh_pkg::BASE_LENGTH)
        else $error("ok result with short header length");

    a_err_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != mlp_msh_pkg::ST_OK) |->
            (o_header_length == 6'd0 && o_peak_rate == 34'd0))
        else $error("error result carries field data");

    a_hold_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready && n_emit) |=> !o_in_ready)
        else $error("input not stalled behind held result");

endmodule
